// ===== src/cct_pkg.sv =====
// Package with types, constants and the divider step function for the CCT core.
`timescale 1ns / 1ps

package cct_pkg;

  // Field widths.
  localparam int unsigned CountW    = 16;
  localparam int unsigned SumW      = 18;
  localparam int unsigned AtimeW    = 8;
  localparam int unsigned CyclesW   = 9;
  localparam int unsigned LevelW    = 17;
  localparam int unsigned KelvinW   = 16;
  localparam int unsigned SlopeW    = 12;
  localparam int unsigned DividendW = CountW + SlopeW;

  // Divider organization: quotient bits resolved per pipeline stage.
  localparam int unsigned DivBits   = 4;
  localparam int unsigned DivStages = DividendW / DivBits;

  // Algorithm constants.
  localparam logic [AtimeW-1:0]  AtimeReset   = 8'd255;
  localparam logic [CyclesW-1:0] CycleTotal   = 9'd256;
  localparam logic [CyclesW-1:0] CycleLimit   = 9'd63;
  localparam logic [LevelW-1:0]  DigitalSat   = 17'd65535;
  // 1024 counts per cycle less one quarter is 768 counts per cycle.
  localparam logic [LevelW-1:0]  LevelPerCyc  = 17'd768;
  localparam logic [SlopeW-1:0]  CctSlope     = 12'd3810;
  localparam logic [KelvinW-1:0] CctOffset    = 16'd1391;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StDark    = 2'd1,
    StSat     = 2'd2,
    StRedZero = 2'd3
  } status_e;

  // One RGBC reading.
  typedef struct packed {
    logic [CountW-1:0] red_count;
    logic [CountW-1:0] green_count;
    logic [CountW-1:0] blue_count;
    logic [CountW-1:0] clear_count;
  } item_t;

  // One result.
  typedef struct packed {
    logic [KelvinW-1:0] kelvin;
    status_e            status;
  } result_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [CountW:0] div_step(logic [CountW-1:0] rem,
                                               logic [CountW-1:0] dvs,
                                               logic              din);
    logic [CountW:0] t;
    logic [CountW:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, diff[CountW-1:0]};
    end else begin
      return {1'b0, t[CountW-1:0]};
    end
  endfunction

endpackage

// ===== src/cct_ir_compensated_ratio_core.sv =====
// Pipelined IR-compensated correlated color temperature core.
`timescale 1ns / 1ps

// Takes one RGBC reading per clock on start_i and returns kelvin and status
// on a one-cycle result_valid_o strobe. The core is fully pipelined, so
// busy_o never rises and a new reading may follow in every cycle. The
// pipeline has one front-end stage for the checks and IR correction, one
// multiply stage, seven divider stages of four restoring steps each, and
// one output stage. Write cfg_we_i/cfg_wdata_i (integration time, reset
// 255) only while no reading is in flight.
module cct_ir_compensated_ratio_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  cct_pkg::item_t               item_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic [cct_pkg::AtimeW-1:0]   cfg_wdata_i,
  output logic                         result_valid_o,
  output cct_pkg::result_t             result_o
);

  // Integration time register.
  logic [cct_pkg::AtimeW-1:0] atime_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atime_q <= cct_pkg::AtimeReset;
    end else if (cfg_we_i) begin
      atime_q <= cfg_wdata_i;
    end
  end

  // The pipeline never stalls, so a transaction is taken whenever start is high.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Front end: saturation level, IR estimate and corrected channels.
  logic [cct_pkg::CyclesW-1:0] cycles;
  logic [cct_pkg::LevelW-1:0]  level;
  logic [cct_pkg::SumW-1:0]    sum;
  logic [cct_pkg::SumW-1:0]    excess;
  logic [cct_pkg::CountW-1:0]  ir;
  logic [cct_pkg::CountW-1:0]  red_corr;
  logic [cct_pkg::CountW-1:0]  blue_corr;
  cct_pkg::status_e            status_d;

  always_comb begin
    cycles = cct_pkg::CycleTotal - {1'b0, atime_q};
    if (cycles > cct_pkg::CycleLimit) begin
      level = cct_pkg::DigitalSat;
    end else begin
      level = cct_pkg::LevelW'(cycles) * cct_pkg::LevelPerCyc;
    end
    sum = cct_pkg::SumW'(item_i.red_count) + cct_pkg::SumW'(item_i.green_count)
        + cct_pkg::SumW'(item_i.blue_count);
    excess = sum - cct_pkg::SumW'(item_i.clear_count);
    if (sum > cct_pkg::SumW'(item_i.clear_count)) begin
      ir = excess[cct_pkg::CountW:1];
    end else begin
      ir = '0;
    end
    red_corr  = item_i.red_count - ir;
    blue_corr = item_i.blue_count - ir;
    if (item_i.clear_count == '0) begin
      status_d = cct_pkg::StDark;
    end else if ({1'b0, item_i.clear_count} >= level) begin
      status_d = cct_pkg::StSat;
    end else if (red_corr == '0) begin
      status_d = cct_pkg::StRedZero;
    end else begin
      status_d = cct_pkg::StOk;
    end
  end

  // Stage 1 registers.
  logic                       s1_valid_q;
  cct_pkg::status_e           s1_status_q;
  logic [cct_pkg::CountW-1:0] s1_red_q;
  logic [cct_pkg::CountW-1:0] s1_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_red_q    <= red_corr;
      s1_blue_q   <= blue_corr;
    end
  end

  // Stage 2: scaled blue forms the dividend. Divider stage arrays use index 0
  // for the multiply stage and 1..DivStages for the division steps.
  logic                          dv_valid_q    [cct_pkg::DivStages+1];
  cct_pkg::status_e              dv_status_q   [cct_pkg::DivStages+1];
  logic [cct_pkg::DividendW-1:0] dv_dividend_q [cct_pkg::DivStages+1];
  logic [cct_pkg::CountW-1:0]    dv_divisor_q  [cct_pkg::DivStages+1];
  logic [cct_pkg::CountW-1:0]    dv_rem_q      [cct_pkg::DivStages+1];
  logic [cct_pkg::KelvinW-1:0]   dv_quot_q     [cct_pkg::DivStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid_q[0] <= 1'b0;
    end else begin
      dv_valid_q[0] <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      dv_status_q[0]   <= s1_status_q;
      dv_dividend_q[0] <= cct_pkg::DividendW'(s1_blue_q) *
                          cct_pkg::DividendW'(cct_pkg::CctSlope);
      dv_divisor_q[0]  <= s1_red_q;
      dv_rem_q[0]      <= '0;
      dv_quot_q[0]     <= '0;
    end
  end

  // Divider stages: each resolves DivBits quotient bits, MSB first.
  for (genvar s = 0; s < cct_pkg::DivStages; s++) begin : g_div
    logic [cct_pkg::CountW-1:0]  rem_d;
    logic [cct_pkg::KelvinW-1:0] quot_d;

    always_comb begin
      logic [cct_pkg::CountW:0] step;
      rem_d  = dv_rem_q[s];
      quot_d = dv_quot_q[s];
      for (int j = 0; j < cct_pkg::DivBits; j++) begin
        step   = cct_pkg::div_step(rem_d, dv_divisor_q[s],
                   dv_dividend_q[s][cct_pkg::DividendW-1 - s*cct_pkg::DivBits - j]);
        rem_d  = step[cct_pkg::CountW-1:0];
        quot_d = {quot_d[cct_pkg::KelvinW-2:0], step[cct_pkg::CountW]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[s+1] <= 1'b0;
      end else begin
        dv_valid_q[s+1] <= dv_valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (dv_valid_q[s]) begin
        dv_status_q[s+1]   <= dv_status_q[s];
        dv_dividend_q[s+1] <= dv_dividend_q[s];
        dv_divisor_q[s+1]  <= dv_divisor_q[s];
        dv_rem_q[s+1]      <= rem_d;
        dv_quot_q[s+1]     <= quot_d;
      end
    end
  end

  // Output stage: add the offset, force zero on an error status.
  logic             out_valid_q;
  cct_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= dv_valid_q[cct_pkg::DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_valid_q[cct_pkg::DivStages]) begin
      out_q.status <= dv_status_q[cct_pkg::DivStages];
      if (dv_status_q[cct_pkg::DivStages] == cct_pkg::StOk) begin
        out_q.kelvin <= dv_quot_q[cct_pkg::DivStages] + cct_pkg::CctOffset;
      end else begin
        out_q.kelvin <= '0;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // An error result always reports zero kelvin.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != cct_pkg::StOk) |-> (result_o.kelvin == '0))
    else $error("error status with nonzero kelvin");

  // A reading that passed the checks always carries a nonzero divisor.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_status_q == cct_pkg::StOk) |-> (s1_red_q != '0))
    else $error("ok status with zero corrected red");

  // The final remainder is below the divisor for every valid division.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid_q[cct_pkg::DivStages] && dv_status_q[cct_pkg::DivStages] == cct_pkg::StOk)
      |-> (dv_rem_q[cct_pkg::DivStages] < dv_divisor_q[cct_pkg::DivStages]))
    else $error("divider remainder not below divisor");

  // A result leaves in the cycle after the last divider stage held a valid item.
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid_q[cct_pkg::DivStages] |=> result_valid_o)
    else $error("divider result lost before output");

endmodule

// ===== tb/cct_ir_compensated_ratio_core_tb.sv =====
// Self-checking testbench for the IR-compensated color temperature core.
`timescale 1ns / 1ps

module cct_ir_compensated_ratio_core_tb;

  localparam int unsigned SLOPE        = 3810;
  localparam int unsigned OFFSET_K     = 1391;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DIR_ROWS     = 20;

  // Typed results for the error cases of the directed rows.
  localparam cct_pkg::result_t DARK_RES     = '{16'd0, cct_pkg::StDark};
  localparam cct_pkg::result_t SAT_RES      = '{16'd0, cct_pkg::StSat};
  localparam cct_pkg::result_t RED_ZERO_RES = '{16'd0, cct_pkg::StRedZero};

  // One directed stimulus row: register setting, reading, optional typed result.
  typedef struct packed {
    logic [cct_pkg::AtimeW-1:0] atime;
    cct_pkg::item_t             rd;
    logic                       typed;
    cct_pkg::result_t           want;
  } dir_row_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start_i     = 1'b0;
  cct_pkg::item_t             item_i      = '0;
  logic                       busy_o;
  logic                       cfg_we_i    = 1'b0;
  logic [cct_pkg::AtimeW-1:0] cfg_wdata_i = '0;
  logic                       result_valid_o;
  cct_pkg::result_t           result_o;

  // Typed expectation that travels with the reading being offered.
  logic             tb_typed = 1'b0;
  cct_pkg::result_t tb_want  = '0;

  // Expected results in order of acceptance.
  cct_pkg::result_t kelvin_pending [$];
  logic [cct_pkg::AtimeW-1:0] model_atime = cct_pkg::AtimeReset;
  logic [cct_pkg::AtimeW-1:0] cur_atime   = cct_pkg::AtimeReset;
  bit                         idle_en     = 1'b1;
  int unsigned                mismatches  = 0;

  dir_row_t dir_rows [DIR_ROWS];

  cct_ir_compensated_ratio_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .item_i        (item_i),
    .busy_o        (busy_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Saturation threshold of the clear channel for an integration setting.
  function automatic logic [16:0] sat_level(input logic [cct_pkg::AtimeW-1:0] at);
    logic [8:0]  cycles;
    logic [18:0] raw;
    cycles = 9'd256 - {1'b0, at};
    raw    = {cycles, 10'b0};
    if (cycles > 9'd63) begin
      return 17'd65535;
    end
    return 17'(raw - raw / 4);
  endfunction

  // Expected kelvin and status for one reading.
  function automatic cct_pkg::result_t predict_cct(input cct_pkg::item_t rd,
                                                   input logic [cct_pkg::AtimeW-1:0] at);
    logic [17:0]      sum;
    logic [17:0]      excess;
    logic [15:0]      ir;
    logic [15:0]      red_c;
    logic [15:0]      blue_c;
    logic [31:0]      quot;
    cct_pkg::result_t res;
    res.kelvin = '0;
    res.status = cct_pkg::StOk;
    if (rd.clear_count == 16'd0) begin
      res.status = cct_pkg::StDark;
    end else if ({1'b0, rd.clear_count} >= sat_level(at)) begin
      res.status = cct_pkg::StSat;
    end else begin
      sum    = 18'(rd.red_count) + 18'(rd.green_count) + 18'(rd.blue_count);
      excess = sum - 18'(rd.clear_count);
      ir     = (sum > 18'(rd.clear_count)) ? excess[16:1] : 16'd0;
      red_c  = rd.red_count - ir;
      blue_c = rd.blue_count - ir;
      if (red_c == 16'd0) begin
        res.status = cct_pkg::StRedZero;
      end else begin
        quot       = (SLOPE * 32'(blue_c)) / 32'(red_c);
        res.kelvin = 16'(quot + OFFSET_K);
      end
    end
    return res;
  endfunction

  // Random reading, mostly unsaturated with the IR term in play.
  function automatic cct_pkg::item_t random_reading(input logic [cct_pkg::AtimeW-1:0] at);
    cct_pkg::item_t rd;
    logic [16:0]    lvl;
    int unsigned    mode;
    int unsigned    tot;
    int unsigned    lo;
    int unsigned    hi;
    lvl  = sat_level(at);
    mode = $urandom_range(99);
    rd   = {$urandom, $urandom};
    if (mode < 20) begin
      // Fully random counts.
    end else if (mode < 65) begin
      rd.clear_count = 16'($urandom_range(lvl - 1, 1));
      rd.red_count   = 16'($urandom_range(rd.clear_count, 0));
      rd.green_count = 16'($urandom_range(rd.clear_count, 0));
      rd.blue_count  = 16'($urandom_range(rd.clear_count, 0));
    end else if (mode < 77) begin
      // Red is cancelled exactly by the inferred IR.
      rd.clear_count = 16'($urandom_range(lvl - 1, 1));
      rd.red_count   = 16'($urandom_range(65535, 1));
      tot = rd.red_count + rd.clear_count + $urandom_range(1);
      lo  = (tot > 65535) ? tot - 65535 : 0;
      hi  = (tot < 65535) ? tot : 65535;
      rd.blue_count  = 16'($urandom_range(hi, lo));
      rd.green_count = 16'(tot - rd.blue_count);
    end else if (mode < 83) begin
      rd.clear_count = 16'd0;
    end else if (mode < 92) begin
      case ($urandom_range(2))
        0: rd.clear_count = 16'(lvl - 1);
        1: rd.clear_count = 16'(lvl);
        default: rd.clear_count = 16'($urandom_range(65535, lvl));
      endcase
    end else begin
      // Tiny red against large blue drives the kelvin sum past 16 bits.
      rd.clear_count = 16'(lvl - 1);
      rd.red_count   = 16'($urandom_range(8, 1));
      rd.green_count = 16'd0;
      rd.blue_count  = 16'($urandom_range(lvl - 1 - rd.red_count, 0));
    end
    return rd;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, what);
    end
  endtask

  // Result checking first, then capture of the accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    cct_pkg::result_t want;
    if (!rst_ni) begin
      model_atime = cct_pkg::AtimeReset;
    end else begin
      if (result_valid_o) begin
        if (kelvin_pending.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kelvin=%0d status=%0d",
                                  result_o.kelvin, result_o.status));
        end else begin
          want = kelvin_pending.pop_front();
          if (result_o.kelvin !== want.kelvin) begin
            flag_mismatch($sformatf("kelvin expected %0d got %0d",
                                    want.kelvin, result_o.kelvin));
          end
          if (result_o.status !== want.status) begin
            flag_mismatch($sformatf("status expected %0d got %0d",
                                    want.status, result_o.status));
          end
        end
      end
      if (start_i && !busy_o) begin
        kelvin_pending.push_back(tb_typed ? tb_want : predict_cct(item_i, model_atime));
      end
      if (cfg_we_i) begin
        model_atime = cfg_wdata_i;
      end
    end
  end

  // Offer one reading, with random idle cycles ahead of it.
  task automatic send_reading(input cct_pkg::item_t rd, input logic typed,
                              input cct_pkg::result_t want);
    while (idle_en && $urandom_range(99) < 9) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    item_i   <= rd;
    tb_typed <= typed;
    tb_want  <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Hold off until every outstanding transaction has returned.
  task automatic wait_drained();
    start_i  <= 1'b0;
    tb_typed <= 1'b0;
    @(posedge clk_i);
    while (kelvin_pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_atime(input logic [cct_pkg::AtimeW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_atime   = v;
  endtask

  // Run watchdog.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence.
  initial begin
    logic [cct_pkg::AtimeW-1:0] phase_atime [6];
    // Shortest integration: dark, saturated, red-zero and ordinary cases.
    dir_rows[0]  = '{8'd255, '{16'h0000, 16'h0000, 16'h0000, 16'd0},     1'b1, DARK_RES};
    dir_rows[1]  = '{8'd255, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0},     1'b1, DARK_RES};
    dir_rows[2]  = '{8'd255, '{16'h0000, 16'h0000, 16'h0000, 16'd768},   1'b1, SAT_RES};
    dir_rows[3]  = '{8'd255, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},  1'b1, SAT_RES};
    dir_rows[4]  = '{8'd255, '{16'h0000, 16'h0000, 16'h0000, 16'd767},   1'b1, RED_ZERO_RES};
    dir_rows[5]  = '{8'd255, '{16'd100, 16'd100, 16'd100, 16'd500},      1'b0, '0};
    dir_rows[6]  = '{8'd255, '{16'd300, 16'd300, 16'd300, 16'd600},      1'b0, '0};
    dir_rows[7]  = '{8'd255, '{16'd100, 16'd100, 16'd100, 16'd100},      1'b1, RED_ZERO_RES};
    dir_rows[8]  = '{8'd255, '{16'h0000, 16'hFFFF, 16'hFFFF, 16'd767},   1'b0, '0};
    dir_rows[9]  = '{8'd255, '{16'd1, 16'd0, 16'd766, 16'd767},          1'b0, '0};
    // Longest integration below the digital limit.
    dir_rows[10] = '{8'd193, '{16'h0000, 16'h0000, 16'h0000, 16'd48384}, 1'b1, SAT_RES};
    dir_rows[11] = '{8'd193, '{16'd5000, 16'd4000, 16'd3000, 16'd48383}, 1'b0, '0};
    // First setting at the digital limit.
    dir_rows[12] = '{8'd192, '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF},  1'b1, SAT_RES};
    dir_rows[13] = '{8'd192, '{16'd1, 16'd0, 16'd65533, 16'd65534},      1'b0, '0};
    dir_rows[14] = '{8'd192, '{16'd7, 16'd9, 16'd11, 16'd65534},         1'b0, '0};
    // Longest integration.
    dir_rows[15] = '{8'd0,   '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF},  1'b1, SAT_RES};
    dir_rows[16] = '{8'd0,   '{16'hFFFF, 16'h0000, 16'hFFFF, 16'd65534}, 1'b0, '0};
    dir_rows[17] = '{8'd0,   '{16'd1, 16'd1, 16'd1, 16'd1},              1'b0, '0};
    dir_rows[18] = '{8'd0,   '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1},     1'b0, '0};
    dir_rows[19] = '{8'd0,   '{16'd2, 16'h5555, 16'hAAAA, 16'hFFFE},     1'b0, '0};

    phase_atime = '{8'd255, 8'd0, 8'd192, 8'd193, 8'($urandom), 8'($urandom)};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; the register changes only between drained groups.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].atime != cur_atime) begin
        set_atime(dir_rows[i].atime);
      end
      send_reading(dir_rows[i].rd, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases over several integration settings.
    foreach (phase_atime[p]) begin
      set_atime(phase_atime[p]);
      idle_en = (p != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) begin
          wait_drained();
        end
        send_reading(random_reading(cur_atime), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0 && kelvin_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
